// File: rtl/polyline_segment_direction_top_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef POLYLINE_SEGMENT_DIRECTION_TOP_MACROS_SVH
`define POLYLINE_SEGMENT_DIRECTION_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PSD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define PSD_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// File: rtl/psd_pkg.sv
package psd_pkg;

   localparam int MAX_VERTICES  = 1024;
   localparam int DIR_FRAC_BITS = 14;

   localparam int COORD_W = 20;
   localparam int MAG_W   = 20;
   localparam int ROOT_W  = 21;
   localparam int SQ_W    = 2 * ROOT_W;
   localparam int LEN_W   = 21;
   localparam int RAD_W   = 20;
   localparam int DIR_W   = 16;
   localparam int VIDX_W  = 10;
   localparam int CNT_W   = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
   localparam int DIV_STEPS = DIR_FRAC_BITS + 1;
   localparam int STEP_W  = $clog2(ROOT_W + DIV_STEPS + 2);

   typedef struct packed {
      logic signed [COORD_W-1:0] x_coord;
      logic signed [COORD_W-1:0] y_coord;
      logic                      final_vertex;
   } req_type;

   typedef struct packed {
      logic [VIDX_W-1:0]       vertex_index;
      logic [LEN_W-1:0]        segment_length;
      logic signed [DIR_W-1:0] dir_x;
      logic signed [DIR_W-1:0] dir_y;
      logic [RAD_W-1:0]        radius;
      logic                    degenerate;
      logic                    end_of_run;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic run;
   } step_type;

endpackage

// File: rtl/polyline_segment_direction_top.sv
// An accepted word runs through the bit-serial squarer, the digit-serial square roots,
// the dividers and a store state; a new word is accepted only once the sequencer is
// back in its idle state, so one vertex is computed at a time.
// Results wait in a two-word output buffer while the next vertex computes; a buffer
// without room for a vertex's results holds the sequencer in its store state.
// Reset (synchronous, active high) empties the buffer and clears the previous vertex.
`include "polyline_segment_direction_top_macros.svh"

module polyline_segment_direction_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  psd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output psd_pkg::rsp_type rsp_data
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_SQRT = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_PUSH = 3'd4;

   localparam int MW = psd_pkg::MAG_W;
   localparam int SW = psd_pkg::SQ_W;
   localparam int CW = psd_pkg::CNT_W;
   localparam int DW = psd_pkg::DIR_W;
   localparam int QN = psd_pkg::DIV_STEPS;

   logic [2:0]                state_ff, state_in;
   logic [psd_pkg::STEP_W-1:0] step_ff, step_in;

   logic signed [psd_pkg::COORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [psd_pkg::COORD_W-1:0] px_ff, px_in, py_ff, py_in;
   logic          fin_ff, fin_in;
   logic          have_ff, have_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [psd_pkg::RAD_W-1:0] rmax_ff, rmax_in;

   logic [MW-1:0] mrx_ff, mrx_in, mry_ff, mry_in, mdx_ff, mdx_in, mdy_ff, mdy_in;
   logic [SW-1:0] arx_ff, arx_in, ary_ff, ary_in, adx_ff, adx_in, ady_ff, ady_in;
   logic [SW-1:0] sumr_ff, sumr_in, sumd_ff, sumd_in;
   logic [MW-1:0] magdx_ff, magdx_in, magdy_ff, magdy_in;
   logic          sdx_ff, sdx_in, sdy_ff, sdy_in;

   logic [MW-1:0] mag_x, mag_y, mag_dx, mag_dy;
   logic signed [psd_pkg::COORD_W:0] dx_w, dy_w;

   psd_pkg::step_type sqrt_ctl, div_ctl;
   logic [psd_pkg::ROOT_W-1:0] root_r, root_d;
   logic [QN-1:0] q_x, q_y;

   psd_pkg::rsp_type ent_ff [2];
   psd_pkg::rsp_type ent_in [2];
   logic       head_ff, head_in;
   logic [1:0] fill_ff, fill_in;
   logic       pop;
   logic [1:0] need;
   logic       push_ok;

   psd_pkg::rsp_type res_seg, res_fin;
   logic [psd_pkg::RAD_W-1:0] r_now, rmax_new;
   logic [DW-1:0] dirx_new, diry_new;
   logic          len_zero;
   logic [CW-1:0] pidx;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (fill_ff != 2'd0);
   assign rsp_data  = ent_ff[head_ff];
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      mag_x  = MW'(req_data.x_coord[psd_pkg::COORD_W-1] ? -req_data.x_coord
                                                       : req_data.x_coord);
      mag_y  = MW'(req_data.y_coord[psd_pkg::COORD_W-1] ? -req_data.y_coord
                                                       : req_data.y_coord);
      dx_w   = {req_data.x_coord[psd_pkg::COORD_W-1], req_data.x_coord}
             - {px_ff[psd_pkg::COORD_W-1], px_ff};
      dy_w   = {req_data.y_coord[psd_pkg::COORD_W-1], req_data.y_coord}
             - {py_ff[psd_pkg::COORD_W-1], py_ff};
      mag_dx = MW'(dx_w[psd_pkg::COORD_W] ? -dx_w : dx_w);
      mag_dy = MW'(dy_w[psd_pkg::COORD_W] ? -dy_w : dy_w);
   end

   assign sqrt_ctl.load = (state_ff == ST_SQRT) && (step_ff == '0);
   assign sqrt_ctl.run  = (state_ff == ST_SQRT) && (step_ff != '0);
   assign div_ctl.load  = (state_ff == ST_DIV) && (step_ff == '0);
   assign div_ctl.run   = (state_ff == ST_DIV) && (step_ff != '0);

   psd_isqrt u_sqrt_r (.clock(clock), .ctl(sqrt_ctl), .value(sumr_ff), .root(root_r));
   psd_isqrt u_sqrt_d (.clock(clock), .ctl(sqrt_ctl), .value(sumd_ff), .root(root_d));

   psd_div u_div_x (.clock(clock), .ctl(div_ctl), .mag(magdx_ff), .len(root_d), .quot(q_x));
   psd_div u_div_y (.clock(clock), .ctl(div_ctl), .mag(magdy_ff), .len(root_d), .quot(q_y));

   // Result words for the segment ending here and for a final vertex.
   always_comb begin
      r_now    = psd_pkg::RAD_W'(root_r);
      rmax_new = (r_now > rmax_ff) ? r_now : rmax_ff;
      len_zero = (root_d == '0);
      dirx_new = len_zero ? '0 : DW'(sdx_ff ? -{1'b0, q_x} : {1'b0, q_x});
      diry_new = len_zero ? '0 : DW'(sdy_ff ? -{1'b0, q_y} : {1'b0, q_y});
      pidx     = (cnt_ff == '0) ? CW'(psd_pkg::MAX_VERTICES - 1) : cnt_ff - CW'(1);

      res_seg.vertex_index   = psd_pkg::VIDX_W'(pidx);
      res_seg.segment_length = root_d;
      res_seg.dir_x          = dirx_new;
      res_seg.dir_y          = diry_new;
      res_seg.radius         = rmax_new;
      res_seg.degenerate     = len_zero;
      res_seg.end_of_run     = 1'b0;

      res_fin.vertex_index   = psd_pkg::VIDX_W'(cnt_ff);
      res_fin.segment_length = '0;
      res_fin.dir_x          = have_ff ? dirx_new : '0;
      res_fin.dir_y          = have_ff ? diry_new : '0;
      res_fin.radius         = rmax_new;
      res_fin.degenerate     = 1'b0;
      res_fin.end_of_run     = 1'b1;

      need    = {1'b0, have_ff} + {1'b0, fin_ff};
      push_ok = (state_ff == ST_PUSH) && ({1'b0, need} <= (3'd2 - {1'b0, fill_ff}));
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff + psd_pkg::STEP_W'(1);
      x_in = x_ff;  y_in = y_ff;  fin_in = fin_ff;
      px_in = px_ff;  py_in = py_ff;  have_in = have_ff;
      cnt_in = cnt_ff;  rmax_in = rmax_ff;
      mrx_in = mrx_ff >> 1;  mry_in = mry_ff >> 1;
      mdx_in = mdx_ff >> 1;  mdy_in = mdy_ff >> 1;
      arx_in = arx_ff << 1;  ary_in = ary_ff << 1;
      adx_in = adx_ff << 1;  ady_in = ady_ff << 1;
      sumr_in = sumr_ff;  sumd_in = sumd_ff;
      magdx_in = magdx_ff;  magdy_in = magdy_ff;  sdx_in = sdx_ff;  sdy_in = sdy_ff;
      ent_in[0] = ent_ff[0];  ent_in[1] = ent_ff[1];
      head_in = pop ? ~head_ff : head_ff;
      fill_in = fill_ff - {1'b0, pop};

      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (req_valid) begin
               state_in = ST_MUL;
               x_in = req_data.x_coord;  y_in = req_data.y_coord;
               fin_in = req_data.final_vertex;
               mrx_in = mag_x;  mry_in = mag_y;  mdx_in = mag_dx;  mdy_in = mag_dy;
               arx_in = SW'(mag_x);  ary_in = SW'(mag_y);
               adx_in = SW'(mag_dx); ady_in = SW'(mag_dy);
               magdx_in = mag_dx;  magdy_in = mag_dy;
               sdx_in = dx_w[psd_pkg::COORD_W];  sdy_in = dy_w[psd_pkg::COORD_W];
               sumr_in = '0;  sumd_in = '0;
            end
         end
         ST_MUL: begin
            // One multiplier bit of each square per cycle.
            sumr_in = sumr_ff + (mrx_ff[0] ? arx_ff : '0) + (mry_ff[0] ? ary_ff : '0);
            sumd_in = sumd_ff + (mdx_ff[0] ? adx_ff : '0) + (mdy_ff[0] ? ady_ff : '0);
            if (step_ff == psd_pkg::STEP_W'(MW - 1)) begin
               state_in = ST_SQRT;
               step_in  = '0;
            end
         end
         ST_SQRT: begin
            if (step_ff == psd_pkg::STEP_W'(psd_pkg::ROOT_W)) begin
               state_in = ST_DIV;
               step_in  = '0;
            end
         end
         ST_DIV: begin
            if (step_ff == psd_pkg::STEP_W'(QN)) begin
               state_in = ST_PUSH;
               step_in  = '0;
            end
         end
         ST_PUSH: begin
            step_in = '0;
            if (push_ok) begin
               state_in = ST_IDLE;
               if (need == 2'd2) begin
                  ent_in[0] = res_seg;
                  ent_in[1] = res_fin;
                  head_in   = 1'b0;
               end else if (need == 2'd1) begin
                  ent_in[head_in ^ (fill_ff[0] & ~pop)] = have_ff ? res_seg : res_fin;
               end
               fill_in = fill_ff - {1'b0, pop} + need;
               if (fin_ff) begin
                  px_in = '0;  py_in = '0;  have_in = 1'b0;
                  cnt_in = '0;  rmax_in = '0;
               end else begin
                  px_in = x_ff;  py_in = y_ff;  have_in = 1'b1;  rmax_in = rmax_new;
                  cnt_in = (cnt_ff == CW'(psd_pkg::MAX_VERTICES - 1)) ? '0
                                                                      : cnt_ff + CW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         px_ff    <= '0;
         py_ff    <= '0;
         have_ff  <= 1'b0;
         cnt_ff   <= '0;
         rmax_ff  <= '0;
         head_ff  <= 1'b0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         px_ff    <= px_in;
         py_ff    <= py_in;
         have_ff  <= have_in;
         cnt_ff   <= cnt_in;
         rmax_ff  <= rmax_in;
         head_ff  <= head_in;
         fill_ff  <= fill_in;
      end
      x_ff <= x_in;  y_ff <= y_in;  fin_ff <= fin_in;
      mrx_ff <= mrx_in;  mry_ff <= mry_in;  mdx_ff <= mdx_in;  mdy_ff <= mdy_in;
      arx_ff <= arx_in;  ary_ff <= ary_in;  adx_ff <= adx_in;  ady_ff <= ady_in;
      sumr_ff <= sumr_in;  sumd_ff <= sumd_in;
      magdx_ff <= magdx_in;  magdy_ff <= magdy_in;  sdx_ff <= sdx_in;  sdy_ff <= sdy_in;
      ent_ff[0] <= ent_in[0];
      ent_ff[1] <= ent_in[1];
   end

   `PSD_NEVER(a_fill_range, fill_ff == 2'd3, "output buffer over two words")
   `PSD_ASSERT(a_accept_starts, (req_valid && req_ready) |=> (state_ff == ST_MUL),
               "accepted word did not start the squarer")
   `PSD_ASSERT(a_last_pop, (pop && fill_ff == 2'd1 && !push_ok) |=> !rsp_valid,
               "buffer not empty after its last word left")
   `PSD_ASSERT(a_push_idle, push_ok |=> (state_ff == ST_IDLE),
               "sequencer did not return to idle after storing results")
endmodule

// File: rtl/psd_isqrt.sv
module psd_isqrt (
   input  logic                       clock,
   input  psd_pkg::step_type          ctl,
   input  logic [psd_pkg::SQ_W-1:0]   value,
   output logic [psd_pkg::ROOT_W-1:0] root
);
   localparam int REM_W = psd_pkg::ROOT_W + 2;

   logic [psd_pkg::SQ_W-1:0]   val_ff, val_in;
   logic [REM_W-1:0]           rem_ff, rem_in;
   logic [psd_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [REM_W+1:0]           t;
   logic [REM_W+1:0]           trial;

   // While run is set, two radicand bits enter per cycle and one root bit leaves.
   always_comb begin
      t       = {rem_ff, val_ff[psd_pkg::SQ_W-1 -: 2]};
      trial   = (REM_W + 2)'({root_ff, 2'b01});
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (ctl.load) begin
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
      end else if (ctl.run) begin
         val_in = {val_ff[psd_pkg::SQ_W-3:0], 2'b00};
         if (t >= trial) begin
            rem_in  = REM_W'(t - trial);
            root_in = {root_ff[psd_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(t);
            root_in = {root_ff[psd_pkg::ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;
endmodule

// File: rtl/psd_div.sv
module psd_div (
   input  logic                          clock,
   input  psd_pkg::step_type             ctl,
   input  logic [psd_pkg::MAG_W-1:0]     mag,
   input  logic [psd_pkg::LEN_W-1:0]     len,
   output logic [psd_pkg::DIV_STEPS-1:0] quot
);
   localparam int N = psd_pkg::DIV_STEPS;
   localparam int L = psd_pkg::LEN_W;

   logic [L-1:0] rem_ff, rem_in;
   logic [L-1:0] den_ff, den_in;
   logic [N-1:0] num_ff, num_in;
   logic [N-1:0] quot_ff, quot_in;
   logic [L:0]   t;

   // The magnitude never exceeds the length, so the quotient has N bits and
   // the top of the shifted numerator already sits below the divisor.
   always_comb begin
      t       = {rem_ff, num_ff[N-1]};
      rem_in  = rem_ff;
      den_in  = den_ff;
      num_in  = num_ff;
      quot_in = quot_ff;
      if (ctl.load) begin
         rem_in  = L'(mag >> 1);
         den_in  = len;
         num_in  = {mag[0], {(N-1){1'b0}}};
         quot_in = '0;
      end else if (ctl.run) begin
         num_in = {num_ff[N-2:0], 1'b0};
         if (t >= {1'b0, den_ff}) begin
            rem_in  = L'(t - {1'b0, den_ff});
            quot_in = {quot_ff[N-2:0], 1'b1};
         end else begin
            rem_in  = L'(t);
            quot_in = {quot_ff[N-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;
endmodule
